[hdl/point_rotate_scale_assert.svh]
// Assertion macros shared by the point rotate and scale RTL.
// Needs clk and arst_n in the scope of every module that uses them.
`ifndef POINT_ROTATE_SCALE_ASSERT_SVH
`define POINT_ROTATE_SCALE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define PRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Checked at every clock edge, reset included.
`define PRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define PRS_ASSERT(lbl, prop, msg)
`define PRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/prs_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and the sine table for the point rotate and scale block.
// Used by prs_div_cell and point_rotate_scale; depends on nothing.
package prs_pkg;

	localparam int COORD_W = 16;
	localparam int ANG_W = 10;
	localparam int SCALE_W = 10;
	localparam int TRIG_W = 17;
	localparam int QUO_W = 37;
	localparam int DIV_STEPS = QUO_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] FWD_DIVISOR = 10'd100;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd100;
	localparam logic [21:0] PCT_Q = 22'd3276800;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 2'd0,
		REG_ANGLE  = 2'd1,
		REG_HSCALE = 2'd2,
		REG_VSCALE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                      mode;
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
	} pt_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic                      sat_flag;
	} res_word_t;

	// One lane of the restoring divider: partial remainder, dividend that
	// shifts out at the top while quotient bits shift in at the bottom.
	typedef struct packed {
		logic [SCALE_W-1:0] rem;
		logic [QUO_W-1:0]   dq;
		logic [SCALE_W-1:0] dvs;
	} lane_t;

	typedef struct packed {
		logic                      en;
		logic                      inv;
		logic                      zdiv;
		logic                      xneg;
		logic                      yneg;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [TRIG_W-1:0]  c;
		logic signed [TRIG_W-1:0]  s;
	} side_t;

	typedef struct packed {
		lane_t lx;
		lane_t ly;
		side_t side;
	} cell_t;

	// round(sin(d) * 32768) for d = 0..90 degrees.
	localparam logic [15:0] SIN_TAB [0:90] = '{
		16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
		16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
		16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
		16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
		16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
		16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
		16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
		16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
		16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
		16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
		16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
		16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
		16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	// Reduces a signed angle to 0..359 degrees.
	function automatic logic [8:0] reduce_angle(input logic signed [ANG_W-1:0] ang);
		logic signed [ANG_W:0] t;
		t = (ANG_W+1)'(ang);
		if (t < 0) t = t + 11'sd360;
		if (t < 0) t = t + 11'sd360;
		if (t >= 11'sd360) t = t - 11'sd360;
		return t[8:0];
	endfunction

	// Sine of a whole angle in 0..359 degrees, 1.0 held as 32768.
	function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [8:0] a);
		logic [6:0] idx;
		logic       neg;
		logic [TRIG_W-1:0] mag;
		if (a <= 9'd90) begin
			idx = a[6:0];
			neg = 1'b0;
		end else if (a <= 9'd180) begin
			idx = 7'(9'd180 - a);
			neg = 1'b0;
		end else if (a <= 9'd270) begin
			idx = 7'(a - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - a);
			neg = 1'b1;
		end
		mag = {1'b0, SIN_TAB[idx]};
		return neg ? $signed(-mag) : $signed(mag);
	endfunction

	// Cosine as the sine of the angle plus a quarter turn.
	function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [8:0] a);
		logic [9:0] b;
		b = {1'b0, a} + 10'd90;
		if (b >= 10'd360) b = b - 10'd360;
		return sin_deg(b[8:0]);
	endfunction

endpackage

[hdl/prs_div_cell.sv]
`timescale 1ns / 1ps
// One restoring division step for the x and y lanes, with side data carried along.
// Depends on prs_pkg and point_rotate_scale_assert.svh.
`include "point_rotate_scale_assert.svh"
module prs_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_in,
	input  prs_pkg::cell_t cell_in,
	output logic           vld_out,
	output prs_pkg::cell_t cell_out
);

	logic           vld_q;
	prs_pkg::cell_t data_q;
	prs_pkg::cell_t data_nxt;

	function automatic prs_pkg::lane_t step(input prs_pkg::lane_t l);
		logic [prs_pkg::SCALE_W:0] t;
		logic [prs_pkg::SCALE_W:0] d;
		logic                      ge;
		prs_pkg::lane_t            r;
		t = {l.rem, l.dq[prs_pkg::QUO_W-1]};
		ge = (t >= {1'b0, l.dvs});
		d = t - {1'b0, l.dvs};
		r = l;
		r.rem = ge ? d[prs_pkg::SCALE_W-1:0] : t[prs_pkg::SCALE_W-1:0];
		r.dq = {l.dq[prs_pkg::QUO_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		data_nxt = cell_in;
		data_nxt.lx = step(cell_in.lx);
		data_nxt.ly = step(cell_in.ly);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= data_nxt;
		end
	end

	assign vld_out = vld_q;
	assign cell_out = data_q;

	`PRS_ASSERT(a_rem_x, vld_q && (data_q.lx.dvs != '0) |-> (data_q.lx.rem < data_q.lx.dvs), "x remainder not below divisor")
	`PRS_ASSERT(a_rem_y, vld_q && (data_q.ly.dvs != '0) |-> (data_q.ly.rem < data_q.ly.dvs), "y remainder not below divisor")
	`PRS_ASSERT(a_fwd_dvs, vld_q && !data_q.side.inv |-> (data_q.lx.dvs == prs_pkg::FWD_DIVISOR) && (data_q.ly.dvs == prs_pkg::FWD_DIVISOR), "forward word with wrong divisor")

endmodule

[hdl/point_rotate_scale.sv]
`timescale 1ns / 1ps
// Top level of the point rotate and scale block: config registers, front
// arithmetic, a chain of prs_div_cell steps and the back rotation stages.
// Depends on prs_pkg, prs_div_cell and point_rotate_scale_assert.svh.
//
// Usage: input words (mode, x_in, y_in) arrive on pt with pt_valid/pt_ready;
// result words (x_out, y_out, sat_flag) leave on res with res_valid/res_ready.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata, one register per
// cycle; the user must do so only while no word is in flight (not enforced).
// A word accepted into the first front stage passes 5 front stages, 37 divider
// cells, 4 back stages and the output register before it appears on res. One
// word is taken per cycle while the receiver does not stall; the 37-cell divider
// chain works one quotient bit per cell on every word in flight.
// The whole pipeline advances when the output register is empty or is being
// taken. When the receiver stalls, every stage holds and pt_ready drops, so
// nothing is lost; the output register keeps its word stable until taken.
// Reset clears all valid bits and sets enable 0, angle 0 and both scales to
// 100 percent; the block takes a word in the first cycle after reset.
`include "point_rotate_scale_assert.svh"
module point_rotate_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_ready,
	input  prs_pkg::pt_word_t                   pt,
	output logic                                res_valid,
	input  logic                                res_ready,
	output prs_pkg::res_word_t                  res,
	input  logic                                cfg_we,
	input  logic [prs_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [prs_pkg::SCALE_W-1:0]         cfg_wdata
);

	// Data carried behind the divider chain.
	typedef struct packed {
		prs_pkg::side_t                     side;
		logic signed [prs_pkg::COORD_W-1:0] fx;
		logic signed [prs_pkg::COORD_W-1:0] fy;
		logic                               fflag;
	} tail_t;

	localparam logic signed [58:0] T_MAX = 59'sd32767;
	localparam logic signed [58:0] T_MIN = -59'sd32768;

	// Configuration registers.
	logic                               en_q;
	logic signed [prs_pkg::ANG_W-1:0]   ang_q;
	logic [prs_pkg::SCALE_W-1:0]        hs_q;
	logic [prs_pkg::SCALE_W-1:0]        vs_q;

	logic adv;
	logic accept;

	// Front stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	prs_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	logic [prs_pkg::SCALE_W-1:0] h_s1, v_s1, h_s2, v_s2, h_s3, v_s3, h_s4, v_s4;
	logic signed [32:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic [36:0] dx_s2, dy_s2, dx_s3, dy_s3, dx_s4, dy_s4;
	logic signed [33:0] r_s3, q_s3;
	logic signed [43:0] rh_s4, qv_s4;
	prs_pkg::cell_t cin_s5;

	// Divider chain.
	logic           cell_vld [0:prs_pkg::DIV_STEPS];
	prs_pkg::cell_t cell_d   [0:prs_pkg::DIV_STEPS];

	// Back stages.
	logic vld_s6, vld_s7, vld_s8, vld_s9;
	tail_t tail_s6, tail_s7, tail_s8, tail_s9;
	logic signed [37:0] ux_s6, uy_s6;
	logic signed [37:0] xhc_s7, xlc_s7, xhs_s7, xls_s7;
	logic signed [37:0] yhc_s7, ylc_s7, yhs_s7, yls_s7;
	logic signed [38:0] hx_s8, lx_s8, hy_s8, ly_s8;
	logic signed [58:0] sx_s9, sy_s9;

	// Output register.
	logic               res_vld_q;
	prs_pkg::res_word_t res_q;

	// Combinational helpers.
	logic [8:0]                        ang_red;
	logic signed [prs_pkg::TRIG_W-1:0] c_now, s_now;
	logic [15:0]                       ax_s1, ay_s1;
	logic [43:0]                       arh_s4, aqv_s4;
	prs_pkg::cell_t                    cin_nxt;
	prs_pkg::cell_t                    cout;
	logic [16:0]                       fxr, fyr;
	logic signed [37:0]                uqx, uqy;
	logic signed [18:0]                uxh, uyh;
	logic signed [19:0]                uxl, uyl;
	logic signed [prs_pkg::TRIG_W-1:0] ns_s6;
	logic signed [58:0]                tx, ty;
	logic signed [prs_pkg::COORD_W-1:0] ix, iy;
	logic                              isat_x, isat_y;
	prs_pkg::res_word_t                res_nxt;

	// The pipeline moves as one; a stall of the receiver holds every stage.
	assign adv = !res_vld_q || res_ready;
	assign pt_ready = adv;
	assign accept = pt_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			ang_q <= '0;
			hs_q  <= prs_pkg::SCALE_RESET;
			vs_q  <= prs_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (prs_pkg::cfg_reg_t'(cfg_idx))
				prs_pkg::REG_ENABLE: en_q  <= cfg_wdata[0];
				prs_pkg::REG_ANGLE:  ang_q <= $signed(cfg_wdata);
				prs_pkg::REG_HSCALE: hs_q  <= cfg_wdata;
				prs_pkg::REG_VSCALE: vs_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Cosine and sine of the configured angle, taken with each word.
	assign ang_red = prs_pkg::reduce_angle(ang_q);
	assign c_now = prs_pkg::cos_deg(ang_red);
	assign s_now = prs_pkg::sin_deg(ang_red);

	// Magnitudes of the input coordinates for the inverse dividends.
	assign ax_s1 = side_s1.x[15] ? 16'(-side_s1.x) : 16'(side_s1.x);
	assign ay_s1 = side_s1.y[15] ? 16'(-side_s1.y) : 16'(side_s1.y);

	// Forward dividends are the scaled rotation with 15 fraction bits dropped,
	// divided by 100 in the chain; inverse dividends are |x| * 3276800 divided
	// by the scale factor.
	assign arh_s4 = rh_s4[43] ? 44'(-rh_s4) : 44'(rh_s4);
	assign aqv_s4 = qv_s4[43] ? 44'(-qv_s4) : 44'(qv_s4);

	always_comb begin
		cin_nxt = '0;
		cin_nxt.side = side_s4;
		cin_nxt.side.zdiv = side_s4.inv && ((h_s4 == '0) || (v_s4 == '0));
		if (side_s4.inv) begin
			cin_nxt.lx.dq = dx_s4;
			cin_nxt.ly.dq = dy_s4;
			cin_nxt.lx.dvs = h_s4;
			cin_nxt.ly.dvs = v_s4;
			cin_nxt.side.xneg = side_s4.x[15];
			cin_nxt.side.yneg = side_s4.y[15];
		end else begin
			cin_nxt.lx.dq = 37'(arh_s4[43:15]);
			cin_nxt.ly.dq = 37'(aqv_s4[43:15]);
			cin_nxt.lx.dvs = prs_pkg::FWD_DIVISOR;
			cin_nxt.ly.dvs = prs_pkg::FWD_DIVISOR;
			cin_nxt.side.xneg = rh_s4[43];
			cin_nxt.side.yneg = qv_s4[43];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= cell_vld[prs_pkg::DIV_STEPS];
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			res_vld_q <= vld_s9;
		end
	end

	// Front payload: capture, products, rotation sums, scale products.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= '{en: en_q, inv: pt.mode, zdiv: 1'b0, xneg: 1'b0, yneg: 1'b0,
				x: pt.x_in, y: pt.y_in, c: c_now, s: s_now};
			h_s1 <= hs_q;
			v_s1 <= vs_q;

			side_s2 <= side_s1;
			h_s2 <= h_s1;
			v_s2 <= v_s1;
			pxc_s2 <= 33'(side_s1.x) * 33'(side_s1.c);
			pys_s2 <= 33'(side_s1.y) * 33'(side_s1.s);
			pyc_s2 <= 33'(side_s1.y) * 33'(side_s1.c);
			pxs_s2 <= 33'(side_s1.x) * 33'(side_s1.s);
			dx_s2 <= 37'(ax_s1) * 37'(prs_pkg::PCT_Q);
			dy_s2 <= 37'(ay_s1) * 37'(prs_pkg::PCT_Q);

			side_s3 <= side_s2;
			h_s3 <= h_s2;
			v_s3 <= v_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			r_s3 <= 34'(pxc_s2) + 34'(pys_s2);
			q_s3 <= 34'(pyc_s2) - 34'(pxs_s2);

			side_s4 <= side_s3;
			h_s4 <= h_s3;
			v_s4 <= v_s3;
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;
			rh_s4 <= 44'(r_s3) * 44'($signed({1'b0, h_s3}));
			qv_s4 <= 44'(q_s3) * 44'($signed({1'b0, v_s3}));

			cin_s5 <= cin_nxt;
		end
	end

	assign cell_vld[0] = vld_s5;
	assign cell_d[0] = cin_s5;

	for (genvar i = 0; i < prs_pkg::DIV_STEPS; i++) begin : g_div
		prs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.vld_in   (cell_vld[i]),
			.cell_in  (cell_d[i]),
			.vld_out  (cell_vld[i+1]),
			.cell_out (cell_d[i+1])
		);
	end

	assign cout = cell_d[prs_pkg::DIV_STEPS];

	// Forward result: the quotient is the truncated magnitude; clamp on its side.
	function automatic logic [16:0] fwd_fix(input logic [36:0] q, input logic neg);
		logic        sat;
		logic [15:0] val;
		logic [36:0] nq;
		nq = -q;
		if (neg) begin
			sat = (q > 37'd32768);
			val = sat ? prs_pkg::COORD_MIN : nq[15:0];
		end else begin
			sat = (q > 37'd32767);
			val = sat ? prs_pkg::COORD_MAX : q[15:0];
		end
		return {sat, val};
	endfunction

	assign fxr = fwd_fix(cout.lx.dq, cout.side.xneg);
	assign fyr = fwd_fix(cout.ly.dq, cout.side.yneg);
	assign uqx = $signed({1'b0, cout.lx.dq});
	assign uqy = $signed({1'b0, cout.ly.dq});

	// Unscaled coordinates are split into a signed high part and an unsigned
	// low part of 19 bits, so that each product stays narrow.
	assign uxh = ux_s6[37:19];
	assign uyh = uy_s6[37:19];
	assign uxl = $signed({1'b0, ux_s6[18:0]});
	assign uyl = $signed({1'b0, uy_s6[18:0]});
	assign ns_s6 = -tail_s6.side.s;

	// Back payload: inverse rotation of the unscaled point.
	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s6 <= '{side: cout.side, fx: $signed(fxr[15:0]), fy: $signed(fyr[15:0]),
				fflag: fxr[16] || fyr[16]};
			ux_s6 <= cout.side.xneg ? -uqx : uqx;
			uy_s6 <= cout.side.yneg ? -uqy : uqy;

			tail_s7 <= tail_s6;
			xhc_s7 <= 38'(uxh) * 38'(tail_s6.side.c);
			xlc_s7 <= 38'(uxl) * 38'(tail_s6.side.c);
			xhs_s7 <= 38'(uyh) * 38'(ns_s6);
			xls_s7 <= 38'(uyl) * 38'(ns_s6);
			yhc_s7 <= 38'(uyh) * 38'(tail_s6.side.c);
			ylc_s7 <= 38'(uyl) * 38'(tail_s6.side.c);
			yhs_s7 <= 38'(uxh) * 38'(tail_s6.side.s);
			yls_s7 <= 38'(uxl) * 38'(tail_s6.side.s);

			tail_s8 <= tail_s7;
			hx_s8 <= 39'(xhc_s7) + 39'(xhs_s7);
			lx_s8 <= 39'(xlc_s7) + 39'(xls_s7);
			hy_s8 <= 39'(yhc_s7) + 39'(yhs_s7);
			ly_s8 <= 39'(ylc_s7) + 39'(yls_s7);

			tail_s9 <= tail_s8;
			sx_s9 <= (59'(hx_s8) <<< 19) + 59'(lx_s8);
			sy_s9 <= (59'(hy_s8) <<< 19) + 59'(ly_s8);

			res_q <= res_nxt;
		end
	end

	// Divide the rotated sums by 32768, rounding toward zero, then clamp.
	assign tx = sx_s9[58] ? ((sx_s9 + 59'sd32767) >>> 15) : (sx_s9 >>> 15);
	assign ty = sy_s9[58] ? ((sy_s9 + 59'sd32767) >>> 15) : (sy_s9 >>> 15);
	assign isat_x = (tx > T_MAX) || (tx < T_MIN);
	assign isat_y = (ty > T_MAX) || (ty < T_MIN);
	assign ix = (tx > T_MAX) ? prs_pkg::COORD_MAX :
		((tx < T_MIN) ? prs_pkg::COORD_MIN : tx[15:0]);
	assign iy = (ty > T_MAX) ? prs_pkg::COORD_MAX :
		((ty < T_MIN) ? prs_pkg::COORD_MIN : ty[15:0]);

	// Final word: pass through when disabled, the saturated limits for a zero
	// scale in inverse mode, else the forward or inverse result.
	always_comb begin
		if (!tail_s9.side.en) begin
			res_nxt = '{x_out: tail_s9.side.x, y_out: tail_s9.side.y, sat_flag: 1'b0};
		end else if (!tail_s9.side.inv) begin
			res_nxt = '{x_out: tail_s9.fx, y_out: tail_s9.fy, sat_flag: tail_s9.fflag};
		end else if (tail_s9.side.zdiv) begin
			res_nxt.x_out = tail_s9.side.x[15] ? prs_pkg::COORD_MIN : prs_pkg::COORD_MAX;
			res_nxt.y_out = tail_s9.side.y[15] ? prs_pkg::COORD_MIN : prs_pkg::COORD_MAX;
			res_nxt.sat_flag = 1'b1;
		end else begin
			res_nxt = '{x_out: ix, y_out: iy, sat_flag: isat_x || isat_y};
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

	`PRS_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !res_valid, "result valid during reset")
	`PRS_ASSERT(a_sat_limit, res_valid && res.sat_flag |-> (res.x_out == prs_pkg::COORD_MAX) || (res.x_out == prs_pkg::COORD_MIN) || (res.y_out == prs_pkg::COORD_MAX) || (res.y_out == prs_pkg::COORD_MIN), "flagged word with no coordinate at a limit")
	`PRS_ASSERT(a_zdiv_flag, adv && vld_s9 && tail_s9.side.en && tail_s9.side.zdiv |=> res_valid && res.sat_flag, "zero scale word without flag")
	`PRS_ASSERT(a_bypass_clean, adv && vld_s9 && !tail_s9.side.en |=> res_valid && !res.sat_flag, "bypassed word flagged")

endmodule
